### hw/rtl/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Types, codes, character constants and helper functions shared by the
// source token scanner modules.
// ----------------------------------------------------------------------------
package sts_pkg;

   localparam int KEYWORD_MAX_LEN_DEF = 8;
   localparam int POS_W   = 24;
   localparam int LEN_W   = 16;
   localparam int KIND_W  = 6;
   localparam int ERR_W   = 3;
   localparam int SLOTS   = 4;
   localparam int CNT_W   = 3;
   localparam int KW_NUM  = 24;

   localparam logic [POS_W-1:0] POS_MAX = '1;
   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   // token kinds
   localparam logic [KIND_W-1:0] K_FUNCTION     = 6'd3;
   localparam logic [KIND_W-1:0] K_END          = 6'd5;
   localparam logic [KIND_W-1:0] K_IF           = 6'd6;
   localparam logic [KIND_W-1:0] K_THEN         = 6'd7;
   localparam logic [KIND_W-1:0] K_ELSE         = 6'd8;
   localparam logic [KIND_W-1:0] K_FI           = 6'd9;
   localparam logic [KIND_W-1:0] K_AND          = 6'd19;
   localparam logic [KIND_W-1:0] K_OR           = 6'd20;
   localparam logic [KIND_W-1:0] K_XOR          = 6'd21;
   localparam logic [KIND_W-1:0] K_NOT          = 6'd22;
   localparam logic [KIND_W-1:0] K_COMMENT      = 6'd24;
   localparam logic [KIND_W-1:0] K_IDENT        = 6'd25;
   localparam logic [KIND_W-1:0] K_NUMBER       = 6'd26;
   localparam logic [KIND_W-1:0] K_ASSIGN       = 6'd27;
   localparam logic [KIND_W-1:0] K_INEQ         = 6'd28;
   localparam logic [KIND_W-1:0] K_LE           = 6'd29;
   localparam logic [KIND_W-1:0] K_ROL          = 6'd30;
   localparam logic [KIND_W-1:0] K_SHL          = 6'd31;
   localparam logic [KIND_W-1:0] K_LT           = 6'd32;
   localparam logic [KIND_W-1:0] K_NEWLINE      = 6'd33;
   localparam logic [KIND_W-1:0] K_AND_OP       = 6'd34;
   localparam logic [KIND_W-1:0] K_DIV          = 6'd35;
   localparam logic [KIND_W-1:0] K_USHR         = 6'd36;
   localparam logic [KIND_W-1:0] K_ROR          = 6'd37;
   localparam logic [KIND_W-1:0] K_SHR          = 6'd38;
   localparam logic [KIND_W-1:0] K_GE           = 6'd39;
   localparam logic [KIND_W-1:0] K_GT           = 6'd40;
   localparam logic [KIND_W-1:0] K_OR_OP        = 6'd41;
   localparam logic [KIND_W-1:0] K_INVALID      = 6'd42;
   localparam logic [KIND_W-1:0] K_COLON        = 6'd43;
   localparam logic [KIND_W-1:0] K_EQUALITY     = 6'd44;
   localparam logic [KIND_W-1:0] K_EQUAL_SIGN   = 6'd45;
   localparam logic [KIND_W-1:0] K_SHORT_AND    = 6'd46;
   localparam logic [KIND_W-1:0] K_SHORT_OR     = 6'd47;
   localparam logic [KIND_W-1:0] K_OPEN         = 6'd48;
   localparam logic [KIND_W-1:0] K_AT           = 6'd49;
   localparam logic [KIND_W-1:0] K_STAR         = 6'd50;
   localparam logic [KIND_W-1:0] K_SEMI         = 6'd51;
   localparam logic [KIND_W-1:0] K_PLUS         = 6'd52;
   localparam logic [KIND_W-1:0] K_MINUS        = 6'd53;
   localparam logic [KIND_W-1:0] K_PERCENT      = 6'd54;
   localparam logic [KIND_W-1:0] K_CLOSE        = 6'd55;
   localparam logic [KIND_W-1:0] K_LBRACK       = 6'd56;
   localparam logic [KIND_W-1:0] K_RBRACK       = 6'd57;
   localparam logic [KIND_W-1:0] K_LBRACE       = 6'd58;
   localparam logic [KIND_W-1:0] K_RBRACE       = 6'd59;
   localparam logic [KIND_W-1:0] K_EOF          = 6'd60;
   localparam logic [KIND_W-1:0] K_STRING       = 6'd61;
   localparam logic [KIND_W-1:0] K_END_FUNCTION = 6'd62;
   localparam logic [KIND_W-1:0] K_NONE         = 6'd63;

   // error codes
   localparam logic [ERR_W-1:0] ERR_NONE     = 3'd0;
   localparam logic [ERR_W-1:0] ERR_STR_NL   = 3'd1;
   localparam logic [ERR_W-1:0] ERR_STR_END  = 3'd2;
   localparam logic [ERR_W-1:0] ERR_CMT      = 3'd3;
   localparam logic [ERR_W-1:0] ERR_LONE_END = 3'd4;

   // characters
   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_NL      = 8'h0A;
   localparam logic [7:0] CH_SP      = 8'h20;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_SQUOTE  = 8'h27;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_STAR    = 8'h2A;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_MINUS   = 8'h2D;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_COLON   = 8'h3A;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LT      = 8'h3C;
   localparam logic [7:0] CH_EQ      = 8'h3D;
   localparam logic [7:0] CH_GT      = 8'h3E;
   localparam logic [7:0] CH_QUEST   = 8'h3F;
   localparam logic [7:0] CH_AT      = 8'h40;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_UNDER   = 8'h5F;
   localparam logic [7:0] CH_LBRACE  = 8'h7B;
   localparam logic [7:0] CH_BAR     = 8'h7C;
   localparam logic [7:0] CH_RBRACE  = 8'h7D;

   // keyword table; the kind of each keyword is its place in the table
   localparam logic [63:0] KW_TEXT [KW_NUM] = '{
      "const", "dim", "static", "function", "declare", "end", "if", "then",
      "else", "fi", "do", "while", "until", "loop", "break", "continue",
      "return", "tailcall", "call", "and", "or", "xor", "not", "asm"};
   localparam logic [4:0] KW_LEN [KW_NUM] = '{
      5'd5, 5'd3, 5'd6, 5'd8, 5'd7, 5'd3, 5'd2, 5'd4,
      5'd4, 5'd2, 5'd2, 5'd5, 5'd5, 5'd4, 5'd5, 5'd8,
      5'd6, 5'd8, 5'd4, 5'd3, 5'd2, 5'd3, 5'd3, 5'd3};

   typedef enum logic [4:0] {
      MODE_LINESTART, MODE_HASHLINE, MODE_IDLE, MODE_WORD, MODE_NUMBER,
      MODE_LT, MODE_LTLT, MODE_SLASH, MODE_LINECMT, MODE_GT, MODE_GTGT,
      MODE_BSLASH, MODE_COLON, MODE_BANG, MODE_EQ, MODE_AMP, MODE_BAR,
      MODE_LPAREN, MODE_BLOCK, MODE_BLOCKSTAR, MODE_STRING, MODE_DONE
   } mode_type;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0] token_kind;
      logic [POS_W-1:0]  line_number;
      logic [POS_W-1:0]  start_offset;
      logic [LEN_W-1:0]  token_length;
      logic [ERR_W-1:0]  error_code;
      logic              last_of_run;
   } rsp_type;

   typedef struct packed {
      rsp_type [SLOTS-1:0] slot;
      logic [CNT_W-1:0]    count;
   } bundle_type;

   typedef struct packed {
      logic              valid;
      logic [KIND_W-1:0] kind;
      logic [POS_W-1:0]  line;
      logic [POS_W-1:0]  start;
   } held_type;

   typedef struct packed {
      held_type held;
      logic     v0;
      rsp_type  e0;
      logic     v1;
      rsp_type  e1;
   } merge_type;

   typedef struct packed {
      logic full;
      logic nonempty;
   } qstat_type;

   function automatic logic [POS_W-1:0] sat_inc(input logic [POS_W-1:0] v);
      return (v == POS_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic [LEN_W-1:0] tok_len(input logic [POS_W-1:0] s,
                                                input logic [POS_W-1:0] e);
      logic [POS_W-1:0] d;
      d = (e >= s) ? e - s : '0;
      return (d > POS_W'(LEN_MAX)) ? LEN_MAX : d[LEN_W-1:0];
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic [KIND_W-1:0] single_kind(input logic [7:0] c);
      logic [KIND_W-1:0] k;
      case (c)
         CH_QUEST:   k = K_XOR;
         CH_AT:      k = K_AT;
         CH_STAR:    k = K_STAR;
         CH_HASH:    k = K_INEQ;
         CH_SEMI:    k = K_SEMI;
         CH_PLUS:    k = K_PLUS;
         CH_MINUS:   k = K_MINUS;
         CH_PERCENT: k = K_PERCENT;
         CH_RPAREN:  k = K_CLOSE;
         CH_LBRACK:  k = K_LBRACK;
         CH_RBRACK:  k = K_RBRACK;
         CH_LBRACE:  k = K_LBRACE;
         CH_RBRACE:  k = K_RBRACE;
         default:    k = K_INVALID;
      endcase
      return k;
   endfunction

   function automatic logic [KIND_W-1:0] kw_kind(input logic [63:0] text,
                                                 input logic [4:0]  len,
                                                 input logic        overlong);
      logic [KIND_W-1:0] k;
      k = K_IDENT;
      if (!overlong) begin
         for (int i = 0; i < KW_NUM; i++) begin
            if (len == KW_LEN[i] && text == KW_TEXT[i]) begin
               k = KIND_W'(i);
            end
         end
      end
      return k;
   endfunction

   // one raw token through the pairing stage
   function automatic merge_type merge_raw(input held_type          h,
                                           input logic              rv,
                                           input logic [KIND_W-1:0] rk,
                                           input logic [POS_W-1:0]  rline,
                                           input logic [POS_W-1:0]  rstart,
                                           input logic [POS_W-1:0]  rend,
                                           input logic [ERR_W-1:0]  rerr);
      merge_type m;
      logic [KIND_W-1:0] pair;
      m.held = h;
      m.v0 = 1'b0;
      m.e0 = '0;
      m.v1 = 1'b0;
      m.e1 = '0;
      pair = K_NONE;
      if (rv) begin
         if (h.valid) begin
            if (h.kind == K_AND && rk == K_THEN) pair = K_SHORT_AND;
            else if (h.kind == K_OR && rk == K_ELSE) pair = K_SHORT_OR;
            else if (h.kind == K_END && rk == K_IF) pair = K_FI;
            else if (h.kind == K_END && rk == K_FUNCTION) pair = K_END_FUNCTION;
            m.v0 = 1'b1;
            m.held.valid = 1'b0;
            m.e0.line_number  = h.line;
            m.e0.start_offset = h.start;
            if (pair != K_NONE) begin
               m.e0.token_kind   = pair;
               m.e0.token_length = tok_len(h.start, rend);
               m.e0.error_code   = ERR_NONE;
            end else if (h.kind == K_AND) begin
               m.e0.token_kind   = K_AND_OP;
               m.e0.token_length = LEN_W'(3);
               m.e0.error_code   = ERR_NONE;
            end else if (h.kind == K_OR) begin
               m.e0.token_kind   = K_OR_OP;
               m.e0.token_length = LEN_W'(2);
               m.e0.error_code   = ERR_NONE;
            end else begin
               m.e0.token_kind   = K_INVALID;
               m.e0.token_length = LEN_W'(3);
               m.e0.error_code   = ERR_LONE_END;
            end
         end
         if (pair == K_NONE) begin
            if (rk == K_AND || rk == K_OR || rk == K_END) begin
               m.held.valid = 1'b1;
               m.held.kind  = rk;
               m.held.line  = rline;
               m.held.start = rstart;
            end else begin
               m.v1 = 1'b1;
               m.e1.token_kind   = rk;
               m.e1.line_number  = rline;
               m.e1.start_offset = rstart;
               m.e1.token_length = tok_len(rstart, rend);
               m.e1.error_code   = rerr;
            end
         end
      end
      return m;
   endfunction

endpackage

### hw/rtl/source_token_scanner.sv
// ----------------------------------------------------------------------------
// source_token_scanner
// Streaming tokenizer: one source character in, zero to three tokens out.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready/req_data carry one character (or the end mark) per
//   item. rsp_valid/rsp_ready/rsp_data carry one token per item; last_of_run
//   flags the final token caused by a given character.
//   The scanner takes one character per cycle while req_ready is high. All
//   tokens of a character are built in the cycle it is accepted, registered
//   as one bundle in the queue and handed out one per cycle by the output
//   sequencer, so the rate is one character per cycle as long as each
//   character yields at most one token and the receiver does not stall.
//   A two-entry bundle queue parts scanner and sequencer: req_ready drops
//   only when it is full, i.e. when the receiver stalls or a burst of
//   multi-token characters backs up.
//   Reset puts the scanner at line start with line 1, offset 0, and empties
//   the queue. After the end-of-file token, further characters are taken
//   and dropped until the next reset.
// ----------------------------------------------------------------------------
module source_token_scanner #(
   parameter int KEYWORD_MAX_LEN = sts_pkg::KEYWORD_MAX_LEN_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sts_pkg::rsp_type rsp_data
);
   import sts_pkg::*;

   logic       q_push, q_pop, accept;
   bundle_type q_in, q_head;
   qstat_type  q_stat;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;

   sts_front #(.KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_accept (accept),
      .in_data   (req_data),
      .push      (q_push),
      .bundle    (q_in)
   );

   sts_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   sts_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (q_head),
      .head_valid (q_stat.nonempty),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("bundle pushed into a full queue");

   a_held_kinds_hidden: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.token_kind != K_AND && rsp_data.token_kind != K_OR &&
                     rsp_data.token_kind != K_END && rsp_data.token_kind != K_COMMENT))
      else $error("held or internal kind reached the output");

   a_error_kinds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.error_code != ERR_NONE) |->
         (rsp_data.token_kind == K_STRING || rsp_data.token_kind == K_EOF ||
          rsp_data.token_kind == K_INVALID))
      else $error("error code on a token kind that cannot carry one");

   a_empty_pop: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_stat.nonempty)
      else $error("pop from an empty queue");

endmodule

### hw/rtl/sts_front.sv
// ----------------------------------------------------------------------------
// sts_front
// Character scanner and keyword pairing stage: one character per item, all
// results of that character packed into one bundle.
// ----------------------------------------------------------------------------
module sts_front #(
   parameter int KEYWORD_MAX_LEN = sts_pkg::KEYWORD_MAX_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_accept,
   input  sts_pkg::req_type    in_data,
   output logic                push,
   output sts_pkg::bundle_type bundle
);
   import sts_pkg::*;

   localparam int WB  = 8 * KEYWORD_MAX_LEN;
   localparam int RLW = $clog2(KEYWORD_MAX_LEN + 1);

   mode_type         mode_ff, mode_in;
   logic [POS_W-1:0] lc_ff, lc_in;
   logic [POS_W-1:0] off_ff, off_in;
   logic [POS_W-1:0] tstart_ff, tstart_in;
   logic [POS_W-1:0] tl_ff, tl_in;
   logic [RLW-1:0]   rl_ff, rl_in;
   logic [WB-1:0]    word_ff, word_in;
   logic             long_ff, long_in;
   logic             quote_ff, quote_in;
   held_type         held_ff, held_in;

   logic [7:0]        c;
   logic [POS_W-1:0]  p, pn;
   logic              idle_pass, via_ls, inc_line, pend3;
   logic              r1_v, r2_v;
   logic [KIND_W-1:0] r1_k, r2_k;
   logic [POS_W-1:0]  r1_e, r2_e;
   logic [ERR_W-1:0]  r1_err, r2_err;
   logic [POS_W-1:0]  r2_line;
   merge_type         m_a, m_b;
   logic [SLOTS-1:0]  cand_v;
   rsp_type [SLOTS-1:0] cand_e;
   logic [CNT_W-1:0]  cnt;

   always_comb begin
      c  = in_data.end_of_input ? CH_NUL : in_data.char_code;
      p  = off_ff;
      pn = sat_inc(off_ff);

      mode_in   = mode_ff;
      rl_in     = rl_ff;
      word_in   = word_ff;
      long_in   = long_ff;
      quote_in  = quote_ff;
      tstart_in = tstart_ff;
      idle_pass = 1'b0;
      via_ls    = 1'b0;
      inc_line  = 1'b0;
      pend3     = 1'b0;
      r1_v = 1'b0; r1_k = K_INVALID; r1_e = p;  r1_err = ERR_NONE;
      r2_v = 1'b0; r2_k = K_INVALID; r2_e = pn; r2_err = ERR_NONE;

      // first pass: finish or extend the token in progress
      case (mode_ff)
         MODE_LINESTART: begin
            if (c == CH_HASH) mode_in = MODE_HASHLINE;
            else begin
               idle_pass = 1'b1; via_ls = 1'b1;
            end
         end
         MODE_HASHLINE: begin
            if (c == CH_NL) begin
               inc_line = 1'b1; mode_in = MODE_LINESTART;
            end else if (c == CH_NUL) begin
               idle_pass = 1'b1; via_ls = 1'b1;
            end
         end
         MODE_WORD: begin
            if (is_alpha(c) || is_digit(c) || c == CH_UNDER) begin
               if (rl_ff < RLW'(KEYWORD_MAX_LEN)) begin
                  word_in = {word_ff[WB-9:0], c};
                  rl_in   = rl_ff + 1'b1;
               end else long_in = 1'b1;
            end else begin
               r1_v = 1'b1; r1_k = kw_kind(word_ff[63:0], 5'(rl_ff), long_ff);
               idle_pass = 1'b1;
            end
         end
         MODE_NUMBER: begin
            if (!is_digit(c)) begin
               r1_v = 1'b1; r1_k = K_NUMBER; idle_pass = 1'b1;
            end
         end
         MODE_LT: begin
            if (c == CH_MINUS) begin
               r1_v = 1'b1; r1_k = K_ASSIGN; r1_e = pn; mode_in = MODE_IDLE;
            end else if (c == CH_GT) begin
               r1_v = 1'b1; r1_k = K_INEQ; r1_e = pn; mode_in = MODE_IDLE;
            end else if (c == CH_EQ) begin
               r1_v = 1'b1; r1_k = K_LE; r1_e = pn; mode_in = MODE_IDLE;
            end else if (c == CH_LT) mode_in = MODE_LTLT;
            else begin
               r1_v = 1'b1; r1_k = K_LT; idle_pass = 1'b1;
            end
         end
         MODE_LTLT: begin
            if (c == CH_GT) begin
               r1_v = 1'b1; r1_k = K_ROL; r1_e = pn; mode_in = MODE_IDLE;
            end else begin
               r1_v = 1'b1; r1_k = K_SHL; idle_pass = 1'b1;
            end
         end
         MODE_SLASH: begin
            if (c == CH_SLASH) mode_in = MODE_LINECMT;
            else if (c == CH_BSLASH) begin
               r1_v = 1'b1; r1_k = K_AND_OP; r1_e = pn; mode_in = MODE_IDLE;
            end else begin
               r1_v = 1'b1; r1_k = K_DIV; idle_pass = 1'b1;
            end
         end
         MODE_LINECMT: begin
            if (c == CH_NL) begin
               r1_v = 1'b1; r1_k = K_NEWLINE; r1_e = pn;
               inc_line = 1'b1; mode_in = MODE_LINESTART;
            end else if (c == CH_NUL) begin
               r1_v = 1'b1; r1_k = K_NEWLINE;
               idle_pass = 1'b1; via_ls = 1'b1;
            end
         end
         MODE_GT: begin
            if (c == CH_GT) mode_in = MODE_GTGT;
            else if (c == CH_EQ) begin
               r1_v = 1'b1; r1_k = K_GE; r1_e = pn; mode_in = MODE_IDLE;
            end else begin
               r1_v = 1'b1; r1_k = K_GT; idle_pass = 1'b1;
            end
         end
         MODE_GTGT: begin
            if (c == CH_GT) begin
               r1_v = 1'b1; r1_k = K_USHR; r1_e = pn; mode_in = MODE_IDLE;
            end else if (c == CH_LT) begin
               r1_v = 1'b1; r1_k = K_ROR; r1_e = pn; mode_in = MODE_IDLE;
            end else begin
               r1_v = 1'b1; r1_k = K_SHR; idle_pass = 1'b1;
            end
         end
         MODE_BSLASH: begin
            if (c == CH_SLASH) begin
               r1_v = 1'b1; r1_k = K_OR_OP; r1_e = pn; mode_in = MODE_IDLE;
            end else if (c == CH_NL) begin
               inc_line = 1'b1; mode_in = MODE_IDLE;
            end else begin
               r1_v = 1'b1; r1_k = K_INVALID; idle_pass = 1'b1;
            end
         end
         MODE_COLON: begin
            if (c == CH_EQ) begin
               r1_v = 1'b1; r1_k = K_ASSIGN; r1_e = pn; mode_in = MODE_IDLE;
            end else begin
               r1_v = 1'b1; r1_k = K_COLON; idle_pass = 1'b1;
            end
         end
         MODE_BANG: begin
            if (c == CH_EQ) begin
               r1_v = 1'b1; r1_k = K_INEQ; r1_e = pn; mode_in = MODE_IDLE;
            end else begin
               r1_v = 1'b1; r1_k = K_NOT; idle_pass = 1'b1;
            end
         end
         MODE_EQ: begin
            if (c == CH_EQ) begin
               r1_v = 1'b1; r1_k = K_EQUALITY; r1_e = pn; mode_in = MODE_IDLE;
            end else begin
               r1_v = 1'b1; r1_k = K_EQUAL_SIGN; idle_pass = 1'b1;
            end
         end
         MODE_AMP: begin
            if (c == CH_AMP) begin
               r1_v = 1'b1; r1_k = K_SHORT_AND; r1_e = pn; mode_in = MODE_IDLE;
            end else begin
               r1_v = 1'b1; r1_k = K_AND_OP; idle_pass = 1'b1;
            end
         end
         MODE_BAR: begin
            if (c == CH_BAR) begin
               r1_v = 1'b1; r1_k = K_SHORT_OR; r1_e = pn; mode_in = MODE_IDLE;
            end else begin
               r1_v = 1'b1; r1_k = K_OR_OP; idle_pass = 1'b1;
            end
         end
         MODE_LPAREN: begin
            if (c == CH_STAR) mode_in = MODE_BLOCK;
            else begin
               r1_v = 1'b1; r1_k = K_OPEN; idle_pass = 1'b1;
            end
         end
         MODE_BLOCK, MODE_BLOCKSTAR: begin
            if (c == CH_NUL) begin
               pend3 = 1'b1; idle_pass = 1'b1;
            end else if (c == CH_STAR) mode_in = MODE_BLOCKSTAR;
            else if (c == CH_RPAREN && mode_ff == MODE_BLOCKSTAR) mode_in = MODE_IDLE;
            else begin
               inc_line = (c == CH_NL);
               mode_in  = MODE_BLOCK;
            end
         end
         MODE_STRING: begin
            if (c == (quote_ff ? CH_SQUOTE : CH_DQUOTE)) begin
               r1_v = 1'b1; r1_k = K_STRING; r1_e = pn; mode_in = MODE_IDLE;
            end else if (c == CH_NL) begin
               r1_v = 1'b1; r1_k = K_STRING; r1_err = ERR_STR_NL; idle_pass = 1'b1;
            end else if (c == CH_NUL) begin
               r1_v = 1'b1; r1_k = K_STRING; r1_err = ERR_STR_END; idle_pass = 1'b1;
            end
         end
         MODE_DONE: mode_in = MODE_DONE;
         default: idle_pass = 1'b1;
      endcase

      // second pass: start a new token with this character
      if (idle_pass) begin
         mode_in = MODE_IDLE;
         if (c != CH_SP && c != CH_TAB) begin
            tstart_in = p;
            if (is_alpha(c)) begin
               word_in = {{(WB-8){1'b0}}, c};
               rl_in   = RLW'(1);
               long_in = 1'b0;
               mode_in = MODE_WORD;
            end else if (is_digit(c)) mode_in = MODE_NUMBER;
            else begin
               case (c)
                  CH_LT:     mode_in = MODE_LT;
                  CH_SLASH:  mode_in = MODE_SLASH;
                  CH_GT:     mode_in = MODE_GT;
                  CH_BSLASH: mode_in = MODE_BSLASH;
                  CH_COLON:  mode_in = MODE_COLON;
                  CH_BANG:   mode_in = MODE_BANG;
                  CH_EQ:     mode_in = MODE_EQ;
                  CH_AMP:    mode_in = MODE_AMP;
                  CH_BAR:    mode_in = MODE_BAR;
                  CH_LPAREN: mode_in = MODE_LPAREN;
                  CH_DQUOTE: begin
                     quote_in = 1'b0; mode_in = MODE_STRING;
                  end
                  CH_SQUOTE: begin
                     quote_in = 1'b1; mode_in = MODE_STRING;
                  end
                  CH_NL: begin
                     r2_v = 1'b1; r2_k = K_NEWLINE;
                     inc_line = 1'b1; mode_in = MODE_LINESTART;
                  end
                  CH_NUL: begin
                     r2_v = 1'b1; r2_k = K_EOF; r2_e = p;
                     r2_err = pend3 ? ERR_CMT : ERR_NONE;
                     mode_in = MODE_DONE;
                  end
                  default: begin
                     r2_v = 1'b1; r2_k = single_kind(c);
                  end
               endcase
            end
         end
      end

      // every token in this step sees the line count from before it
      r2_line = (r1_v || via_ls) ? lc_ff : tl_ff;
      tl_in   = (r1_v || r2_v || via_ls) ? lc_ff : tl_ff;
      lc_in   = inc_line ? sat_inc(lc_ff) : lc_ff;
      off_in  = (c != CH_NUL) ? pn : off_ff;

      m_a = merge_raw(held_ff, r1_v, r1_k, tl_ff, tstart_ff, r1_e, r1_err);
      m_b = merge_raw(m_a.held, r2_v, r2_k, r2_line, p, r2_e, r2_err);
      held_in = m_b.held;

      cand_v = {m_b.v1, m_b.v0, m_a.v1, m_a.v0};
      cand_e = {m_b.e1, m_b.e0, m_a.e1, m_a.e0};
      bundle = '0;
      cnt    = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (cand_v[i]) begin
            bundle.slot[cnt[1:0]] = cand_e[i];
            cnt = cnt + 1'b1;
         end
      end
      bundle.count = cnt;
      push = in_accept && (mode_ff != MODE_DONE) && (cnt != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_LINESTART;
         lc_ff          <= POS_W'(1);
         off_ff         <= '0;
         tstart_ff      <= '0;
         tl_ff          <= POS_W'(1);
         rl_ff          <= '0;
         long_ff        <= 1'b0;
         quote_ff       <= 1'b0;
         held_ff.valid  <= 1'b0;
         held_ff.kind   <= '0;
         held_ff.line   <= POS_W'(1);
         held_ff.start  <= '0;
      end else if (in_accept && mode_ff != MODE_DONE) begin
         mode_ff   <= mode_in;
         lc_ff     <= lc_in;
         off_ff    <= off_in;
         tstart_ff <= tstart_in;
         tl_ff     <= tl_in;
         rl_ff     <= rl_in;
         long_ff   <= long_in;
         quote_ff  <= quote_in;
         held_ff   <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_accept && mode_ff != MODE_DONE) begin
         word_ff <= word_in;
      end
   end

endmodule

### hw/rtl/sts_queue.sv
// ----------------------------------------------------------------------------
// sts_queue
// Two-entry bundle queue between the scanner and the result sequencer.
// ----------------------------------------------------------------------------
module sts_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  sts_pkg::bundle_type push_data,
   input  logic                pop,
   output sts_pkg::bundle_type head,
   output sts_pkg::qstat_type  stat
);
   import sts_pkg::*;

   bundle_type  mem_ff [2];
   logic        wr_ff, wr_in;
   logic        rd_ff, rd_in;
   logic [1:0]  cnt_ff, cnt_in;

   always_comb begin
      wr_in  = push ? ~wr_ff : wr_ff;
      rd_in  = pop ? ~rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
      head   = mem_ff[rd_ff];
      stat.full     = (cnt_ff == 2'd2);
      stat.nonempty = (cnt_ff != 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

### hw/rtl/sts_back.sv
// ----------------------------------------------------------------------------
// sts_back
// Result sequencer: hands out the results of one bundle, one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module sts_back (
   input  logic                clock,
   input  logic                reset,
   input  sts_pkg::bundle_type head,
   input  logic                head_valid,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output sts_pkg::rsp_type    rsp_data
);
   import sts_pkg::*;

   logic [1:0] idx_ff, idx_in;
   logic       last;

   always_comb begin
      last      = ({1'b0, idx_ff} == head.count - 1'b1);
      rsp_valid = head_valid;
      rsp_data  = head.slot[idx_ff];
      rsp_data.last_of_run = last;
      pop    = head_valid && rsp_ready && last;
      idx_in = idx_ff;
      if (head_valid && rsp_ready) begin
         idx_in = last ? 2'd0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
